// File: hdl/adf_pkg.sv
// Shared types and constants for the ADPCM frame decoder.
`default_nettype none
package adf_pkg;

  localparam int FRAME_BITS = 64;
  localparam int NIB_BITS   = 56;
  localparam int COEF_BITS  = 16;
  localparam int SAMP_BITS  = 16;
  localparam int IDX_BITS   = 4;
  localparam int ACC_BITS   = 34;
  localparam int PROD_BITS  = 32;
  localparam int FRAC_BITS  = 11;

  localparam logic [IDX_BITS-1:0] LAST_IDX = 4'd13;

  // Configuration register indexes
  localparam logic [2:0] REG_COEF_0       = 3'd0;
  localparam logic [2:0] REG_COEF_1       = 3'd1;
  localparam logic [2:0] REG_COEF_2       = 3'd2;
  localparam logic [2:0] REG_COEF_3       = 3'd3;
  localparam logic [2:0] REG_START_RECENT = 3'd4;
  localparam logic [2:0] REG_START_OLDER  = 3'd5;

  // Decoded frame handed from the front end to the sample engine
  typedef struct packed {
    logic [3:0]                  shift;
    logic signed [COEF_BITS-1:0] c1;
    logic signed [COEF_BITS-1:0] c2;
    logic [NIB_BITS-1:0]         nibs;
    logic                        restart;
  } cmd_t;

  // One decoded sample waiting at the output
  typedef struct packed {
    logic signed [SAMP_BITS-1:0] sample;
    logic [IDX_BITS-1:0]         idx;
    logic                        last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN
  } st_t;

endpackage
`default_nettype wire

// File: hdl/adf_front.sv
// Front end: accepts frames, decodes the header and queues a command.
`default_nettype none
module adf_front
  import adf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [FRAME_BITS-1:0] frame_data,
  input  wire logic                  restart,
  output logic                       full,
  input  wire logic [255:0]          coef_all,
  output logic                       cmd_valid,
  output cmd_t                       cmd,
  input  wire logic                  cmd_take
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;
  logic [2:0] pair;
  cmd_t       dec;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push & ~full;
  assign do_take   = cmd_take & cmd_valid;

  // Decode header: scale shift, coefficient pair 2p and 2p+1
  always_comb begin
    pair        = frame_data[62:60];
    dec.shift   = frame_data[59:56];
    dec.c1      = coef_all[{pair, 5'd0} +: COEF_BITS];
    dec.c2      = coef_all[{pair, 5'd16} +: COEF_BITS];
    dec.nibs    = frame_data[NIB_BITS-1:0];
    dec.restart = restart;
  end

  // Hold decoded commands in a two-entry queue
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_take) begin
        count <= count + 2'd1;
      end else if (!do_push && do_take) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("command queue overflow");
  a_push_fills: assert property (@(posedge clk) disable iff (rst) do_push |=> count != 2'd0)
    else $error("accepted frame lost from command queue");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("command queue pointers disagree with count");

endmodule
`default_nettype wire

// File: hdl/adf_back.sv
// Sample engine: runs the two-tap predictor over 14 nibbles and queues samples.
`default_nettype none
module adf_back
  import adf_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  input  wire cmd_t                        cmd,
  output logic                             cmd_take,
  input  wire logic signed [SAMP_BITS-1:0] start_recent,
  input  wire logic signed [SAMP_BITS-1:0] start_older,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [SAMP_BITS-1:0]      sample,
  output logic [IDX_BITS-1:0]              sample_index,
  output logic                             last
);

  st_t state, state_next;

  // Working copy of the current frame
  logic [3:0]                  shift;
  logic signed [COEF_BITS-1:0] c1;
  logic signed [COEF_BITS-1:0] c2;
  logic [NIB_BITS-1:0]         nibs;
  logic                        restart_f;
  logic [IDX_BITS-1:0]         idx;

  // History and the older-tap product computed one step ahead
  logic signed [SAMP_BITS-1:0] h_rec;
  logic signed [SAMP_BITS-1:0] h_old;
  logic signed [PROD_BITS-1:0] p2;

  logic signed [SAMP_BITS-1:0] p2_src;
  logic signed [PROD_BITS-1:0] p2_next;
  logic signed [PROD_BITS-1:0] prod1;
  logic signed [ACC_BITS-1:0]  nib_term;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  quo;
  logic signed [SAMP_BITS-1:0] s;
  logic                        run_step;

  // Output queue
  out_t       oq [2];
  logic       owr;
  logic       ord;
  logic [1:0] ocount;
  logic       room;
  logic       do_pop;

  assign room   = (ocount != 2'd2);
  assign do_pop = pop & ~empty;
  assign empty  = (ocount == 2'd0);
  assign sample       = oq[ord].sample;
  assign sample_index = oq[ord].idx;
  assign last         = oq[ord].last;

  // Sequence: take a command, load history, then one sample per cycle while the output queue has room
  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    run_step   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (room) begin
          run_step = 1'b1;
          if (idx == LAST_IDX) begin
            if (cmd_valid) begin
              cmd_take   = 1'b1;
              state_next = ST_LOAD;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Predictor arithmetic for the current nibble
  always_comb begin
    p2_src   = (state == ST_LOAD) ? (restart_f ? start_older : h_old) : h_rec;
    p2_next  = c2 * p2_src;
    prod1    = c1 * h_rec;
    nib_term = (ACC_BITS'(signed'(nibs[NIB_BITS-1 -: 4])) <<< FRAC_BITS) <<< shift;
    acc      = ACC_BITS'(prod1) + ACC_BITS'(p2) + nib_term + 34'sd1024;
    quo      = acc >>> FRAC_BITS;
    if (quo > 34'sd32767) begin
      s = 16'sh7FFF;
    end else if (quo < -34'sd32768) begin
      s = 16'sh8000;
    end else begin
      s = quo[SAMP_BITS-1:0];
    end
  end

  // Advance frame registers and history
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      shift     <= cmd.shift;
      c1        <= cmd.c1;
      c2        <= cmd.c2;
      nibs      <= cmd.nibs;
      restart_f <= cmd.restart;
    end else if (run_step) begin
      nibs <= nibs << 4;
    end
    if (state == ST_LOAD) begin
      idx <= '0;
      p2  <= p2_next;
    end else if (run_step) begin
      idx <= idx + 4'd1;
      p2  <= p2_next;
    end
    if (rst) begin
      h_rec <= '0;
      h_old <= '0;
    end else if (state == ST_LOAD && restart_f) begin
      h_rec <= start_recent;
      h_old <= start_older;
    end else if (run_step) begin
      h_old <= h_rec;
      h_rec <= s;
    end
  end

  // Queue samples for the consumer
  always_ff @(posedge clk) begin
    if (run_step) begin
      oq[owr].sample <= s;
      oq[owr].idx    <= idx;
      oq[owr].last   <= (idx == LAST_IDX);
    end
    if (rst) begin
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (run_step) begin
        owr <= ~owr;
      end
      if (do_pop) begin
        ord <= ~ord;
      end
      if (run_step && !do_pop) begin
        ocount <= ocount + 2'd1;
      end else if (!run_step && do_pop) begin
        ocount <= ocount - 2'd1;
      end
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (rst) ocount != 2'd3)
    else $error("sample queue overflow");
  a_load_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |=> state == ST_RUN)
    else $error("history load not followed by sample run");
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (run_step && idx == LAST_IDX) |=> (state == ST_LOAD || state == ST_IDLE))
    else $error("run continued past the last sample");
  a_take_valid: assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> idx <= LAST_IDX)
    else $error("sample index out of range");

endmodule
`default_nettype wire

// File: hdl/adpcm_frame_decoder_top.sv
// Top level of the ADPCM frame decoder: configuration registers and the two halves.
// Each frame is a history-load step followed by 14 samples, paced by the
//   single predictor multiply-add that each sample depends on.
// The first sample of a frame passes the command queue, the load state and the run
//   state into the sample queue; the rest follow one per cycle while that queue has room.
// Reset (rst, synchronous, active high) empties the queues and clears history and configuration registers to 0.
`default_nettype none
module adpcm_frame_decoder_top
  import adf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [FRAME_BITS-1:0]  frame_data,
  input  wire logic                   restart,
  output logic                        empty,
  input  wire logic                   pop,
  output logic signed [SAMP_BITS-1:0] sample,
  output logic [IDX_BITS-1:0]         sample_index,
  output logic                        last,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [63:0]            cfg_data
);

  logic [63:0]                 coef_g0;
  logic [63:0]                 coef_g1;
  logic [63:0]                 coef_g2;
  logic [63:0]                 coef_g3;
  logic signed [SAMP_BITS-1:0] start_recent;
  logic signed [SAMP_BITS-1:0] start_older;
  logic                        cmd_valid;
  logic                        cmd_take;
  cmd_t                        cmd;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_g0      <= '0;
      coef_g1      <= '0;
      coef_g2      <= '0;
      coef_g3      <= '0;
      start_recent <= '0;
      start_older  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_0:       coef_g0      <= cfg_data;
        REG_COEF_1:       coef_g1      <= cfg_data;
        REG_COEF_2:       coef_g2      <= cfg_data;
        REG_COEF_3:       coef_g3      <= cfg_data;
        REG_START_RECENT: start_recent <= cfg_data[SAMP_BITS-1:0];
        REG_START_OLDER:  start_older  <= cfg_data[SAMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  adf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .frame_data  (frame_data),
    .restart     (restart),
    .full        (full),
    .coef_all    ({coef_g3, coef_g2, coef_g1, coef_g0}),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  adf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .start_recent (start_recent),
    .start_older  (start_older),
    .empty        (empty),
    .pop          (pop),
    .sample       (sample),
    .sample_index (sample_index),
    .last         (last)
  );

endmodule
`default_nettype wire
